// ----- hw/rtl/mic_pkg.sv -----
// Shared types, codes and sizing constants for the multiset intersection counter.
package mic_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int KEY_W = 32;
	localparam int CNT_W = 16;
	localparam int ENTRY_W = KEY_W + CNT_W;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_PROBE = 2'd2;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_MATCH = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [KEY_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [KEY_W-1:0] matched_value;
	} out_item_t;

	typedef struct packed {
		logic take;
		logic scan;
		logic clear;
		logic upd_inc;
		logic upd_dec;
		logic alloc;
		logic set_match;
		logic set_full;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic fill_zero;
		logic table_full;
		logic hit;
		logic last;
		logic count_max;
		logic count_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ----- hw/rtl/mic_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module mic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/mic_datapath.sv -----
// Datapath: entry memory, fill count, key scan pipeline and result register.
module mic_datapath import mic_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input in_item_t item,
	input dp_cmd_t cmd,
	output dp_status_t sts,
	input logic result_ready,
	output logic result_valid,
	output out_item_t result
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

	in_item_t item_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] addr_q;
	logic [IDX_W-1:0] idx_s1;
	logic rd_valid_s1;
	logic [IDX_W-1:0] hit_idx_q;
	logic [CNT_W-1:0] hit_cnt_q;
	logic [1:0] res_status_q;
	logic out_valid_q;
	out_item_t out_q;

	logic issue;
	logic match;
	logic we;
	logic [IDX_W-1:0] waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;

	assign issue = cmd.scan && (addr_q < fill_q);
	assign match = rd_valid_s1 && (rdata[ENTRY_W-1:CNT_W] == item_q.value);

	always_comb begin
		we = cmd.upd_inc || cmd.upd_dec || cmd.alloc;
		waddr = hit_idx_q;
		wdata = {item_q.value, hit_cnt_q + CNT_W'(1)};
		if (cmd.upd_dec) begin
			wdata = {item_q.value, hit_cnt_q - CNT_W'(1)};
		end
		if (cmd.alloc) begin
			waddr = fill_q[IDX_W-1:0];
			wdata = {item_q.value, CNT_W'(1)};
		end
	end

	mic_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_entries (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(issue),
		.raddr(addr_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			addr_q <= '0;
			rd_valid_s1 <= 1'b0;
			res_status_q <= ST_NONE;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (cmd.take) begin
				addr_q <= '0;
				res_status_q <= ST_NONE;
			end else if (issue) begin
				addr_q <= addr_q + FILL_W'(1);
			end
			if (cmd.clear) begin
				fill_q <= '0;
			end else if (cmd.alloc) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.set_match) begin
				res_status_q <= ST_MATCH;
			end else if (cmd.set_full) begin
				res_status_q <= ST_FULL;
			end
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= item;
		end
		if (issue) begin
			idx_s1 <= addr_q[IDX_W-1:0];
		end
		if (match) begin
			hit_idx_q <= idx_s1;
			hit_cnt_q <= rdata[CNT_W-1:0];
		end
		if (cmd.publish) begin
			out_q.status <= res_status_q;
			out_q.matched_value <= (res_status_q == ST_MATCH) ? item_q.value : '0;
		end
	end

	always_comb begin
		sts.op = item_q.opcode;
		sts.fill_zero = (fill_q == '0);
		sts.table_full = (fill_q == FILL_W'(TABLE_ENTRIES));
		sts.hit = match;
		sts.last = rd_valid_s1 && ((FILL_W'(idx_s1) + FILL_W'(1)) == fill_q);
		sts.count_max = (hit_cnt_q == COUNT_MAX);
		sts.count_zero = (hit_cnt_q == '0);
		sts.out_free = !out_valid_q || result_ready;
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// ----- hw/rtl/mic_ctrl.sv -----
// Controller: sequences clear, scan, update and result hand-off for each item.
module mic_ctrl import mic_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input dp_status_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DISPATCH = 6'b000010,
		S_SCAN = 6'b000100,
		S_HIT = 6'b001000,
		S_MISS = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.take = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.op == OP_CLEAR) begin
					cmd.clear = 1'b1;
					state_d = S_FINISH;
				end else if (sts.op == OP_LOAD || sts.op == OP_PROBE) begin
					if (sts.fill_zero) begin
						state_d = S_MISS;
					end else begin
						cmd.scan = 1'b1;
						state_d = S_SCAN;
					end
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_HIT;
				end else if (sts.last) begin
					state_d = S_MISS;
				end
			end
			S_HIT: begin
				if (sts.op == OP_LOAD) begin
					cmd.upd_inc = !sts.count_max;
				end else begin
					cmd.upd_dec = !sts.count_zero;
					cmd.set_match = !sts.count_zero;
				end
				state_d = S_FINISH;
			end
			S_MISS: begin
				if (sts.op == OP_LOAD) begin
					cmd.alloc = !sts.table_full;
					cmd.set_full = sts.table_full;
				end
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/multiset_intersection_counter_unit.sv -----
// Top level of the multiset intersection counter: controller plus datapath.
// Each item yields exactly one result item. Keys and counts sit in one memory with a
// single registered read port, and a lookup walks the stored keys in order, one entry
// per cycle, up to the number of keys stored so far (fill). A clear or an unused opcode
// goes from dispatch straight to finish; a load or probe scans until its key is found
// or the last stored entry is read (no scan if the table is empty), then takes a hit or
// miss step before finish. A new item is accepted while the previous result still
// waits in the output register. Valid entries always form a prefix of the memory, so a
// fill count marks them and neither reset nor clear sweeps the memory.
module multiset_intersection_counter_unit import mic_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input in_item_t item,
	output logic result_valid,
	input logic result_ready,
	output out_item_t result
);

	dp_cmd_t cmd;
	dp_status_t sts;

	mic_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.sts(sts),
		.cmd(cmd)
	);

	mic_datapath #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.sts(sts),
		.result_ready(result_ready),
		.result_valid(result_valid),
		.result(result)
	);

endmodule

// ----- hw/rtl/mic_checker.sv -----
// Port-level assertions for the multiset intersection counter and their bind.
module mic_checker import mic_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input in_item_t item,
	input logic result_valid,
	input logic result_ready,
	input out_item_t result
);

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input item changed or dropped while waiting");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result item changed or dropped while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status == ST_NONE || result.status == ST_MATCH ||
			result.status == ST_FULL))
		else $error("result item carries an unused status code");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_MATCH |-> result.matched_value == '0)
		else $error("unmatched result item carries a nonzero value");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("block took a second item before finishing the first");

endmodule

bind multiset_intersection_counter_unit mic_checker u_mic_checker (.*);

// ----- tb/tb_multiset_intersection_counter_unit.sv -----
// Self-checking testbench for the multiset intersection counter with a count-table predictor.
`timescale 1ns / 1ps

import mic_pkg::*;

class match_tracker;
	logic [KEY_W-1:0] keys [TABLE_ENTRIES_DEF];
	logic [CNT_W-1:0] tally [TABLE_ENTRIES_DEF];
	bit held [TABLE_ENTRIES_DEF];
	out_item_t due_results [$];
	int errors = 0;

	function new();
		empty_table();
	endfunction

	function void empty_table();
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
			keys[i] = '0;
			tally[i] = '0;
			held[i] = 1'b0;
		end
	endfunction

	function int find_key(logic [KEY_W-1:0] k);
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
			if (held[i] && keys[i] == k) begin
				return i;
			end
		end
		return -1;
	endfunction

	function out_item_t predict_result(in_item_t it);
		out_item_t r;
		int slot;
		r.status = ST_NONE;
		r.matched_value = '0;
		case (it.opcode)
			OP_CLEAR: begin
				empty_table();
			end
			OP_LOAD: begin
				slot = find_key(it.value);
				if (slot >= 0) begin
					if (tally[slot] != COUNT_MAX) begin
						tally[slot] = tally[slot] + CNT_W'(1);
					end
				end else begin
					for (int i = 0; i < TABLE_ENTRIES_DEF && slot < 0; i++) begin
						if (!held[i]) begin
							slot = i;
						end
					end
					if (slot >= 0) begin
						keys[slot] = it.value;
						tally[slot] = CNT_W'(1);
						held[slot] = 1'b1;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			OP_PROBE: begin
				slot = find_key(it.value);
				if (slot >= 0 && tally[slot] != '0) begin
					tally[slot] = tally[slot] - CNT_W'(1);
					r.status = ST_MATCH;
					r.matched_value = it.value;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function void note_item(in_item_t it);
		due_results.insert(due_results.size(), predict_result(it));
	endfunction

	function void check_result(out_item_t r);
		out_item_t want;
		if (due_results.size() == 0) begin
			$error("result item with none expected: status %0d, matched_value %0d",
				r.status, r.matched_value);
			errors++;
			return;
		end
		want = due_results.pop_front();
		if (r.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, r.status);
			errors++;
		end
		if (r.matched_value !== want.matched_value) begin
			$error("matched_value: expected %0d, got %0d", want.matched_value,
				r.matched_value);
			errors++;
		end
	endfunction

	function bit drained();
		return due_results.size() == 0;
	endfunction
endclass

module tb_multiset_intersection_counter_unit;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int LIST_ITEMS = 1450;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_item_t result;

	int send_gap = 0;
	int recv_gap = 0;
	int list_items = 0;
	match_tracker sb = new();

	multiset_intersection_counter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			sb.check_result(result);
		end
		result_ready <= ($urandom_range(99) >= recv_gap);
	end

	task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] val);
		in_item_t it;
		it.opcode = op;
		it.value = val;
		while ($urandom_range(99) < send_gap) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
		if (op == OP_LOAD || op == OP_PROBE) begin
			list_items++;
		end
	endtask

	task automatic hold_until_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (!sb.drained());
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return $urandom_range(15);
			default: return $urandom();
		endcase
	endfunction

	task automatic run_round();
		logic [KEY_W-1:0] pool [$];
		logic [KEY_W-1:0] v;
		int n_items;
		int pick;
		if ($urandom_range(99) < 85) begin
			send_item(OP_CLEAR, $urandom());
		end
		if ($urandom_range(14) == 0) begin
			n_items = TABLE_ENTRIES_DEF + $urandom_range(1, 4);
			repeat (n_items) begin
				v = $urandom();
				pool.insert(pool.size(), v);
				send_item(OP_LOAD, v);
			end
			repeat ($urandom_range(4, 10)) begin
				send_item(OP_PROBE, pool[$urandom_range(pool.size() - 1)]);
			end
		end else begin
			repeat ($urandom_range(1, 8)) begin
				pool.insert(pool.size(), pick_key());
			end
			n_items = $urandom_range(4, 24);
			repeat (n_items) begin
				pick = $urandom_range(99);
				v = pool[$urandom_range(pool.size() - 1)];
				if (pick < 48) begin
					send_item(OP_LOAD, v);
				end else if (pick < 88) begin
					send_item(OP_PROBE, v);
				end else if (pick < 95) begin
					send_item(OP_PROBE, pick_key());
				end else if (pick < 98) begin
					send_item(OP_LOAD, pick_key());
				end else begin
					send_item(OP_UNUSED, $urandom());
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_CLEAR, 32'h0000_0000);
		send_item(OP_LOAD, 32'h8000_0000);
		send_item(OP_LOAD, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 32'h0000_0000);
		send_item(OP_LOAD, 32'hFFFF_FFFF);
		send_item(OP_LOAD, 32'h7FFF_FFFF);
		send_item(OP_PROBE, 32'h7FFF_FFFF);
		send_item(OP_PROBE, 32'h7FFF_FFFF);
		send_item(OP_PROBE, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 32'h7FFF_FFFF);
		send_item(OP_PROBE, 32'h7FFF_FFFF);
		send_item(OP_PROBE, 32'h8000_0000);
		send_item(OP_PROBE, 32'h1234_5678);
		send_item(OP_PROBE, 32'h0000_0000);
		send_item(OP_UNUSED, 32'hFFFF_FFFF);
		send_item(OP_PROBE, 32'hFFFF_FFFF);
		send_item(OP_PROBE, 32'h8000_0000);
		send_item(OP_CLEAR, 32'h5555_5555);
		send_item(OP_PROBE, 32'h0000_0000);
		send_item(OP_LOAD, 32'hAAAA_AAAA);
		send_item(OP_PROBE, 32'hAAAA_AAAA);
		hold_until_drained();

		list_items = 0;
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_gap = 28;
					recv_gap = 66;
				end
				1: begin
					send_gap = 66;
					recv_gap = 28;
				end
				default: begin
					send_gap = 0;
					recv_gap = 0;
				end
			endcase
			while (list_items < (ph + 1) * LIST_ITEMS / 3) begin
				run_round();
			end
			hold_until_drained();
		end

		repeat (80) @(posedge clk);
		if (sb.errors == 0 && sb.drained()) begin
			$display("tb_multiset_intersection_counter_unit: clean");
		end else begin
			$display("tb_multiset_intersection_counter_unit: errors");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("tb_multiset_intersection_counter_unit: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/mic_pkg.sv
hw/rtl/mic_ram.sv
hw/rtl/mic_datapath.sv
hw/rtl/mic_ctrl.sv
hw/rtl/multiset_intersection_counter_unit.sv
hw/rtl/mic_checker.sv
tb/tb_multiset_intersection_counter_unit.sv
